>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When ante holds, cons must hold in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// When ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

>>> sv/upc_pkg.sv
// ---------------------------------------------------------------------------
// upc_pkg
// Types, character constants and helper functions for the URI percent codec.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package upc_pkg;

    // Characters
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // Error codes carried on a result beat
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_HEX    = 2'd1;
    localparam logic [1:0] ERR_UNFINISHED = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W         = 1;
    localparam logic [0:0] CFG_CODEC_MODE    = 1'b0;
    localparam logic [0:0] CFG_RESERVED_MASK = 1'b1;
    localparam int         CFG_DATA_W        = 64;

    // Results one input beat can produce
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_HIGH    = 2'd2,
        PH_DISCARD = 2'd3
    } t_dec_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [1:0] error_code;
    } t_out_beat;

    // Everything one step of the codec yields for the item in the stage
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        t_out_beat [MAX_RESULTS-1:0]       res;
        t_dec_phase                        phase;
        logic [3:0]                        nibble;
    } t_step;

    // Lowercase hex digit for a nibble
    function automatic logic [7:0] hex_lower(input logic [3:0] v);
        logic [7:0] ch;
        if (v < 4'd10) begin
            ch = 8'h30 + {4'd0, v};
        end else begin
            ch = 8'h57 + {4'd0, v};
        end
        return ch;
    endfunction

    // {bad, value}: bad set when c is not 0-9, a-f or A-F
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b0, c[3:0] + 4'd9};
        end else begin
            r = 5'b1_0000;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/upc_step.sv
// ---------------------------------------------------------------------------
// upc_step
// Combinational step of the codec: results and next decode state for one
// input beat, given the mode, the escape mask and the current decode state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module upc_step (
    input  wire upc_pkg::t_in_beat   i_beat,
    input  wire                      i_mode,
    input  wire [63:0]               i_mask,
    input  wire upc_pkg::t_dec_phase i_phase,
    input  wire [3:0]                i_nibble,
    output upc_pkg::t_step           o_step
);
    import upc_pkg::*;

    logic [7:0] c;
    logic       last;
    logic [4:0] hv;
    logic       in_range;
    logic [5:0] mask_idx;
    logic       escape;

    assign c    = i_beat.in_byte;
    assign last = i_beat.in_last;
    assign hv   = hex_value(c);

    // 0x20..0x5F maps to mask bits 0..63
    assign in_range = !c[7] && (c[6] ^ c[5]);
    assign mask_idx = {c[6], c[4:0]};
    assign escape   = in_range && i_mask[mask_idx];

    always_comb begin
        o_step        = '0;
        o_step.phase  = i_phase;
        o_step.nibble = i_nibble;

        if (i_mode) begin
            // Encode: decode state untouched
            if (escape) begin
                o_step.count  = CNT_W'(3);
                o_step.res[0] = '{out_byte: CH_PERCENT, out_last: 1'b0, error_code: ERR_NONE};
                o_step.res[1] = '{out_byte: hex_lower(c[7:4]), out_last: 1'b0,
                                  error_code: ERR_NONE};
                o_step.res[2] = '{out_byte: hex_lower(c[3:0]), out_last: last,
                                  error_code: ERR_NONE};
            end else begin
                o_step.count  = CNT_W'(1);
                o_step.res[0] = '{out_byte: c, out_last: last, error_code: ERR_NONE};
            end
        end else begin
            unique case (i_phase)
                PH_IDLE: begin
                    if (c == CH_PERCENT) begin
                        if (last) begin
                            o_step.count  = CNT_W'(1);
                            o_step.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                              error_code: ERR_UNFINISHED};
                        end else begin
                            o_step.phase = PH_PERCENT;
                        end
                    end else begin
                        o_step.count  = CNT_W'(1);
                        o_step.res[0] = '{out_byte: (c == CH_PLUS) ? CH_SPACE : c,
                                          out_last: last, error_code: ERR_NONE};
                    end
                end
                PH_PERCENT: begin
                    if (last) begin
                        o_step.phase  = PH_IDLE;
                        o_step.count  = CNT_W'(1);
                        o_step.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                          error_code: ERR_UNFINISHED};
                    end else if (hv[4]) begin
                        o_step.phase  = PH_DISCARD;
                        o_step.count  = CNT_W'(1);
                        o_step.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                          error_code: ERR_BAD_HEX};
                    end else begin
                        o_step.nibble = hv[3:0];
                        o_step.phase  = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    o_step.count = CNT_W'(1);
                    if (hv[4]) begin
                        o_step.phase  = last ? PH_IDLE : PH_DISCARD;
                        o_step.res[0] = '{out_byte: 8'd0, out_last: 1'b1,
                                          error_code: ERR_BAD_HEX};
                    end else begin
                        o_step.phase  = PH_IDLE;
                        o_step.res[0] = '{out_byte: {i_nibble, hv[3:0]}, out_last: last,
                                          error_code: ERR_NONE};
                    end
                end
                PH_DISCARD: begin
                    // Drop input up to the end of the string
                    if (last) begin
                        o_step.phase = PH_IDLE;
                    end
                end
                default: begin
                    o_step.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/uri_percent_codec_unit.sv
// URI percent codec. Takes one character beat per cycle while the stage
// is free and gives result beats on a valid/ready output. A beat that
// yields one result or none leaves the stage as it is loaded, so such
// beats stream back to back unless the output stalls; an escaped character
// in encode mode yields three results and holds the stage until the last
// is loaded, as the output register sends one result per cycle while the
// receiver is ready. A result goes through the input stage register, then
// the output register. Configuration writes are always accepted and take
// effect on the next beat; write them only while the block is idle.
// ---------------------------------------------------------------------------
// uri_percent_codec_unit
// Top level: config registers, input stage, result sequencer, output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uri_percent_codec_unit (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // input characters
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire upc_pkg::t_in_beat                i_in_data,
    // results
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output upc_pkg::t_out_beat                    o_out_data,
    // configuration writes
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [upc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [upc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import upc_pkg::*;

    // Config registers
    logic        r_mode;
    logic [63:0] r_mask;

    // Decode state
    t_dec_phase  r_phase;
    logic [3:0]  r_nibble;

    // Input stage
    logic        r_stg_vld;
    t_in_beat    r_stg;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] n_idx;

    // Output register
    logic        r_out_vld;
    t_out_beat   r_out;

    t_step       step;
    logic        slot_free;
    logic        load_out;
    logic        last_res;
    logic        retire;

    upc_step u_step (
        .i_beat   (r_stg),
        .i_mode   (r_mode),
        .i_mask   (r_mask),
        .i_phase  (r_phase),
        .i_nibble (r_nibble),
        .o_step   (step)
    );

    // Sequencing of results out of the stage
    assign slot_free  = !r_out_vld || i_out_ready;
    assign last_res   = (r_idx == step.count - CNT_W'(1));
    assign load_out   = r_stg_vld && (step.count != '0) && slot_free;
    assign retire     = r_stg_vld && ((step.count == '0) || (slot_free && last_res));
    assign n_idx      = retire ? '0 : (load_out ? r_idx + CNT_W'(1) : r_idx);

    assign o_in_ready  = !r_stg_vld || retire;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_mask <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CODEC_MODE:    r_mode <= i_cfg_data[0];
                CFG_RESERVED_MASK: r_mask <= i_cfg_data[63:0];
                default:           ;
            endcase
        end
    end

    // Input stage, decode state and sequencer index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
            r_idx     <= '0;
            r_phase   <= PH_IDLE;
            r_nibble  <= '0;
        end else begin
            r_idx <= n_idx;
            if (o_in_ready) begin
                r_stg_vld <= i_in_valid;
            end
            if (retire) begin
                r_phase  <= step.phase;
                r_nibble <= step.nibble;
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_stg <= i_in_data;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= step.res[r_idx];
        end
    end

    // Checks
    `ASSERT_SAME(a_err_is_last,
                 r_out_vld && (r_out.error_code != ERR_NONE),
                 r_out.out_last && (r_out.out_byte == 8'd0))
    `ASSERT_SAME(a_idx_zero_no_res, r_stg_vld && (step.count == '0), r_idx == '0)
    `ASSERT_SAME(a_stall_has_item, !o_in_ready, r_stg_vld)
    `ASSERT_NEXT(a_load_shows, load_out, r_out_vld)

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for uri_percent_codec_unit. Character beats are fed
// from a queue and the result beats are checked, in order and field by field,
// against a predictor that tracks the decode escape state and the mode/mask
// registers. A directed sequence covers escapes, errors, discard and mode
// switches during an open escape. It is followed by random phases with
// different settings and idle/stall mixes, including one long output hold.
// ---------------------------------------------------------------------------

module tb_top;
    import upc_pkg::*;

    localparam int HOLD_LEN       = 300;   // long output hold, in cycles
    localparam int SETTLE_CYCLES  = 10;    // pause after the last expected beat
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int PHASE_CHARS    = 25;
    localparam int NUM_PHASES     = 7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_beat              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic       o_in_ready;
    logic       o_out_valid;
    t_out_beat  o_out_data;
    logic       o_cfg_ready;

    uri_percent_codec_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stimulus queue and predicted result beats
    t_in_beat  char_q[$];
    t_out_beat codec_out_q[$];

    // Mirror of the block's registers and decode state
    logic        mode_r = 1'b0;
    logic [63:0] mask_r = '0;
    t_dec_phase  dec_phase = PH_IDLE;
    logic [3:0]  hi_nib = '0;

    // Run control and bookkeeping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_cnt       = 0;
    int mismatches     = 0;
    int chars_queued   = 0;
    int chars_taken    = 0;
    int results_seen   = 0;
    int error_beats    = 0;
    int reg_writes     = 0;
    int idle_cycles    = 0;

    // -1 when c is not a hex digit
    function automatic int digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        logic [7:0] ch;
        case (n)
            4'ha: ch = 8'h61;
            4'hb: ch = 8'h62;
            4'hc: ch = 8'h63;
            4'hd: ch = 8'h64;
            4'he: ch = 8'h65;
            4'hf: ch = 8'h66;
            default: ch = {4'h3, n};
        endcase
        return ch;
    endfunction

    function automatic void push_result(input logic [7:0] ch, input logic lst,
                                        input logic [1:0] err);
        t_out_beat r;
        r.out_byte   = ch;
        r.out_last   = lst;
        r.error_code = err;
        codec_out_q.push_back(r);
    endfunction

    // One accepted character: update decode state, queue the result beats
    function automatic void codec_step(input t_in_beat b);
        logic [7:0] c;
        int         d;
        c = b.in_byte;
        d = digit_of(c);
        if (mode_r) begin
            if (c >= 8'h20 && c <= 8'h5F && mask_r[6'(c - 8'h20)]) begin
                push_result(CH_PERCENT, 1'b0, ERR_NONE);
                push_result(nibble_char(c[7:4]), 1'b0, ERR_NONE);
                push_result(nibble_char(c[3:0]), b.in_last, ERR_NONE);
            end else begin
                push_result(c, b.in_last, ERR_NONE);
            end
            return;
        end
        case (dec_phase)
            PH_IDLE: begin
                if (c != CH_PERCENT) begin
                    push_result((c == CH_PLUS) ? CH_SPACE : c, b.in_last, ERR_NONE);
                end else if (b.in_last) begin
                    push_result(8'h00, 1'b1, ERR_UNFINISHED);
                end else begin
                    dec_phase = PH_PERCENT;
                end
            end
            PH_PERCENT: begin
                if (b.in_last) begin
                    dec_phase = PH_IDLE;
                    push_result(8'h00, 1'b1, ERR_UNFINISHED);
                end else if (d < 0) begin
                    dec_phase = PH_DISCARD;
                    push_result(8'h00, 1'b1, ERR_BAD_HEX);
                end else begin
                    hi_nib    = d[3:0];
                    dec_phase = PH_HIGH;
                end
            end
            PH_HIGH: begin
                if (d < 0) begin
                    dec_phase = b.in_last ? PH_IDLE : PH_DISCARD;
                    push_result(8'h00, 1'b1, ERR_BAD_HEX);
                end else begin
                    dec_phase = PH_IDLE;
                    push_result({hi_nib, d[3:0]}, b.in_last, ERR_NONE);
                end
            end
            default: begin
                if (b.in_last) dec_phase = PH_IDLE;
            end
        endcase
    endfunction

    // Input driver: presents queued beats, random gaps between them
    always @(posedge clk) begin : drive_chars
        bit took;
        took = rst_n && in_valid && o_in_ready;
        if (took) begin
            codec_step(in_data);
            chars_taken++;
        end
        if (!in_valid || took) begin
            if (rst_n && char_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= char_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each result beat with the oldest prediction
    always @(posedge clk) begin : check_results
        t_out_beat want;
        if (rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (o_out_data.error_code != ERR_NONE) error_beats++;
            if (codec_out_q.size() == 0) begin
                $error("unexpected result beat: out_byte %02h out_last %0d error_code %0d",
                       o_out_data.out_byte, o_out_data.out_last, o_out_data.error_code);
                mismatches++;
            end else begin
                want = codec_out_q.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, o_out_data.out_byte);
                    mismatches++;
                end
                if (o_out_data.out_last !== want.out_last) begin
                    $error("out_last: expected %0d, got %0d",
                           want.out_last, o_out_data.out_last);
                    mismatches++;
                end
                if (o_out_data.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, got %0d",
                           want.error_code, o_out_data.error_code);
                    mismatches++;
                end
            end
        end
        // one long hold when requested, random stalls otherwise
        if (hold_req && hold_cnt < HOLD_LEN) begin
            hold_cnt  <= hold_cnt + 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: no handshake on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_char(input logic [7:0] ch, input logic lst);
        t_in_beat b;
        b.in_byte = ch;
        b.in_last = lst;
        char_q.push_back(b);
        chars_queued++;
    endtask

    // Register write; block must be idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!(cfg_valid && o_cfg_ready)) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CODEC_MODE) mode_r = val[0];
        else mask_r = val;
        reg_writes++;
    endtask

    // Wait until every beat went in and every predicted result came out
    task automatic drain();
        @(negedge clk);
        while (char_q.size() != 0 || in_valid || codec_out_q.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_hex();
        int k;
        k = $urandom_range(21);
        if (k < 10) return 8'h30 + k[7:0];
        if (k < 16) return 8'h61 + k[7:0] - 8'd10;
        return 8'h41 + k[7:0] - 8'd16;
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        do c = 8'($urandom_range(255)); while (digit_of(c) >= 0);
        return c;
    endfunction

    // Mostly well-formed percent strings, some broken escapes and noise
    task automatic add_decode_line();
        logic [7:0] s[$];
        int         pieces;
        int         kind;
        pieces = $urandom_range(1, 6);
        for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                s.push_back(CH_PERCENT);
                s.push_back(rand_hex());
                s.push_back(rand_hex());
            end else if (kind < 55) begin
                s.push_back(CH_PLUS);
            end else if (kind < 62) begin
                s.push_back(CH_PERCENT);
                s.push_back(rand_hex());
                s.push_back(rand_non_hex());
            end else if (kind < 67) begin
                s.push_back(CH_PERCENT);
                s.push_back(rand_non_hex());
            end else if (kind < 71) begin
                s.push_back(CH_PERCENT);
            end else begin
                s.push_back(8'($urandom_range(255)));
            end
        end
        for (int i = 0; i < s.size(); i++) push_char(s[i], i == s.size() - 1);
    endtask

    task automatic add_encode_char();
        logic [7:0] c;
        if ($urandom_range(99) < 70) c = 8'($urandom_range(8'h5F, 8'h20));
        else c = 8'($urandom_range(255));
        push_char(c, $urandom_range(99) < 30);
    endtask

    initial begin : stimulus
        int          target;
        logic [63:0] mask_val;
        logic        enc;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Decode at reset settings: extremes, plus, good and broken escapes
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b1);
        push_char(CH_PLUS, 1'b1);
        push_char(CH_PERCENT, 1'b0);
        push_char(8'h66, 1'b0);
        push_char(8'h46, 1'b1);
        push_char(CH_PERCENT, 1'b1);                  // ends right after '%'
        push_char(CH_PERCENT, 1'b0);
        push_char(8'h37, 1'b1);                       // ends after first digit
        push_char(CH_PERCENT, 1'b0);
        push_char(8'h67, 1'b0);                       // bad first digit, discard
        push_char(8'h41, 1'b0);
        push_char(8'h25, 1'b1);
        push_char(CH_PERCENT, 1'b0);
        push_char(8'h30, 1'b0);
        push_char(8'h47, 1'b0);                       // bad second digit, discard
        push_char(8'h71, 1'b1);
        push_char(CH_PERCENT, 1'b0);
        push_char(8'h34, 1'b0);
        push_char(8'h7A, 1'b1);                       // bad digit on the last beat
        push_char(CH_PERCENT, 1'b0);                  // escape left open
        drain();

        // Encode with every bit set while that escape stays open
        write_reg(CFG_CODEC_MODE, 64'd1);
        write_reg(CFG_RESERVED_MASK, '1);
        @(negedge clk);
        push_char(8'h20, 1'b0);
        push_char(8'h5F, 1'b1);
        push_char(8'h1F, 1'b0);
        push_char(8'h60, 1'b0);
        push_char(8'hFF, 1'b1);
        drain();

        // Back to decode: the open escape resumes
        write_reg(CFG_CODEC_MODE, 64'd0);
        @(negedge clk);
        push_char(8'h34, 1'b0);
        push_char(8'h31, 1'b1);
        drain();

        // Random phases: settings and idle/stall mixes
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin enc = 1'b0; mask_val = {$urandom, $urandom}; end
                1: begin enc = 1'b1; mask_val = '1; end
                2: begin enc = 1'b1; mask_val = {$urandom, $urandom}; end
                3: begin enc = 1'b1; mask_val = '0; end
                4: begin enc = 1'b1; mask_val = {$urandom, $urandom}; end
                default: begin enc = 1'b0; mask_val = {$urandom, $urandom}; end
            endcase
            // upper bits of the mode write are noise, only bit 0 counts
            write_reg(CFG_CODEC_MODE, {$urandom, $urandom_range(32'hFFFF_FFFF) & ~32'd1} |
                      {63'd0, enc});
            write_reg(CFG_RESERVED_MASK, mask_val);
            @(negedge clk);
            case (ph)
                1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2, 6:    begin send_idle_pct = 0;  recv_stall_pct = 51; end
                3, 5:    begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            // output held off while the sender keeps offering beats
            if (ph == 4) hold_req = 1'b1;
            target = chars_queued + PHASE_CHARS;
            while (chars_queued < target) begin
                if (enc) add_encode_char();
                else add_decode_line();
            end
            drain();
        end

        $display("Run covered %0d characters in, %0d result beats out (%0d with errors),",
                 chars_taken, results_seen, error_beats);
        $display("%0d register writes across decode and encode settings.", reg_writes);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
